### src/assert_macros.svh
// Assertion helpers for the line pixel generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, checked outside reset.
`define BLPG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Property that must never hold, checked outside reset.
`define BLPG_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(prop)) \
    else $error("forbidden condition seen");

`else

`define BLPG_ASSERT(lbl, clk, rst_n, prop)
`define BLPG_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

### src/blpg_pkg.sv
package blpg_pkg;

  localparam int unsigned CoordBits = 10;
  localparam int unsigned ErrBits   = CoordBits + 1;
  localparam int unsigned ColorBits = 24;
  localparam int unsigned AddrBits  = 32;
  localparam int unsigned PitchBits = 16;
  localparam int unsigned PixBBits  = 3;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 32;

  localparam logic ReqStart   = 1'b0;
  localparam logic ReqAdvance = 1'b1;

  localparam logic [CfgIdxBits-1:0] CfgFrameBase  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgRowPitch   = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgPixelBytes = 2'd2;

  localparam logic [AddrBits-1:0]  FrameBaseRst  = 32'd0;
  localparam logic [PitchBits-1:0] RowPitchRst   = 16'd2000;
  localparam logic [PixBBits-1:0]  PixelBytesRst = 3'd4;

  typedef struct packed {
    logic                 req_type;
    logic [CoordBits-1:0] x_start;
    logic [CoordBits-1:0] y_start;
    logic [CoordBits-1:0] x_end;
    logic [CoordBits-1:0] y_end;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
  } blpg_req_t;

  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
    logic [AddrBits-1:0]  pixel_address;
    logic [ColorBits-1:0] pixel_color;
    logic                 last_pixel;
  } blpg_pix_t;

endpackage

### src/bresenham_line_pixel_generator_core.sv
// Line pixel generator.
// Input channel (in_valid_i / in_stall_o / in_req_i): a start transaction
// loads both endpoints and the color and returns nothing; each advance
// transaction returns the next pixel of the active line. An advance with
// no active line, or after a zero-length start, returns nothing.
// Output channel (out_valid_o / out_stall_i / out_pix_o): x, y, byte
// address, packed color and a last flag on the final pixel.
// An accepted advance steps the line state into the pixel stage; from there
// the address is formed through the row multiplier into the output register
// that drives out_pix_o. Throughput: one transaction per cycle while
// in_stall_o is low.
// A stalled output holds; the pixel stage behind it still takes one more
// transaction, and in_stall_o rises only when both stages are full.
// Configuration writes (frame base, row pitch, bytes per pixel) should be
// done while no transaction is in flight.
// Reset clears the line state (no line active) and loads the register
// defaults: base 0, pitch 2000, 4 bytes per pixel.
`include "assert_macros.svh"

module bresenham_line_pixel_generator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  blpg_pkg::blpg_req_t                  in_req_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output blpg_pkg::blpg_pix_t                  out_pix_o,
  input  logic                                 cfg_we_i,
  input  logic [blpg_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [blpg_pkg::CfgDataBits-1:0]     cfg_wdata_i
);
  import blpg_pkg::*;

  localparam int unsigned RowOffBits = CoordBits + PitchBits;
  localparam int unsigned ColOffBits = CoordBits + PixBBits;

  // config
  logic [AddrBits-1:0]  frame_base_q;
  logic [PitchBits-1:0] row_pitch_q;
  logic [PixBBits-1:0]  pixel_bytes_q;

  // line state
  logic [CoordBits-1:0] pos_x_q, pos_x_d;
  logic [CoordBits-1:0] pos_y_q, pos_y_d;
  logic [ErrBits-1:0]   err_acc_q, err_acc_d;
  logic [CoordBits-1:0] steps_left_q, steps_left_d;
  logic [CoordBits-1:0] delta_x_q, delta_x_d;
  logic [CoordBits-1:0] delta_y_q, delta_y_d;
  logic                 step_x_neg_q, step_x_neg_d;
  logic                 step_y_neg_q, step_y_neg_d;
  logic                 x_major_q, x_major_d;
  logic [ColorBits-1:0] line_color_q, line_color_d;
  logic                 line_active_q, line_active_d;

  // pixel stage
  logic                 a_valid_q, a_valid_d;
  logic [CoordBits-1:0] a_x_q;
  logic [CoordBits-1:0] a_y_q;
  logic [ColorBits-1:0] a_color_q;
  logic                 a_last_q;

  // output stage
  logic                 out_valid_q;
  blpg_pix_t            out_pix_q;

  logic a_ready;
  logic b_ready;
  logic in_accept;
  logic is_advance;
  logic gen_pixel;

  logic [CoordBits-1:0] dx_start, dy_start;
  logic [CoordBits-1:0] major_start;
  logic                 xmaj_start;
  logic [CoordBits-1:0] major_delta, minor_delta;
  logic [ErrBits-1:0]   err_sum;
  logic                 minor_step;
  logic [CoordBits-1:0] x_fwd, y_fwd;

  logic [RowOffBits-1:0] row_off;
  logic [ColOffBits-1:0] col_off;
  logic [AddrBits-1:0]   addr_sum;

  function automatic logic [CoordBits-1:0] step_coord(logic [CoordBits-1:0] v, logic neg);
    logic [CoordBits-1:0] one;
    one = CoordBits'(1);
    return neg ? (v - one) : (v + one);
  endfunction

  assign b_ready    = !out_valid_q || !out_stall_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_stall_o = !a_ready;
  assign in_accept  = in_valid_i && a_ready;
  assign is_advance = (in_req_i.req_type == ReqAdvance);
  assign gen_pixel  = in_accept && is_advance && line_active_q;

  // start setup
  always_comb begin
    dx_start    = (in_req_i.x_start > in_req_i.x_end) ? (in_req_i.x_start - in_req_i.x_end)
                                                      : (in_req_i.x_end - in_req_i.x_start);
    dy_start    = (in_req_i.y_start > in_req_i.y_end) ? (in_req_i.y_start - in_req_i.y_end)
                                                      : (in_req_i.y_end - in_req_i.y_start);
    xmaj_start  = dx_start > dy_start;
    major_start = xmaj_start ? dx_start : dy_start;
  end

  // one step along the line
  always_comb begin
    major_delta = x_major_q ? delta_x_q : delta_y_q;
    minor_delta = x_major_q ? delta_y_q : delta_x_q;
    err_sum     = err_acc_q + ErrBits'(minor_delta);
    minor_step  = err_sum > ErrBits'(major_delta);
    x_fwd       = step_coord(pos_x_q, step_x_neg_q);
    y_fwd       = step_coord(pos_y_q, step_y_neg_q);
  end

  always_comb begin
    pos_x_d       = pos_x_q;
    pos_y_d       = pos_y_q;
    err_acc_d     = err_acc_q;
    steps_left_d  = steps_left_q;
    delta_x_d     = delta_x_q;
    delta_y_d     = delta_y_q;
    step_x_neg_d  = step_x_neg_q;
    step_y_neg_d  = step_y_neg_q;
    x_major_d     = x_major_q;
    line_color_d  = line_color_q;
    line_active_d = line_active_q;
    if (in_accept && !is_advance) begin
      delta_x_d     = dx_start;
      delta_y_d     = dy_start;
      step_x_neg_d  = !(in_req_i.x_start < in_req_i.x_end);
      step_y_neg_d  = !(in_req_i.y_start < in_req_i.y_end);
      x_major_d     = xmaj_start;
      pos_x_d       = in_req_i.x_start;
      pos_y_d       = in_req_i.y_start;
      line_color_d  = {in_req_i.red, in_req_i.green, in_req_i.blue};
      steps_left_d  = major_start;
      err_acc_d     = ErrBits'(major_start >> 1);
      line_active_d = (major_start != '0);
    end else if (gen_pixel) begin
      err_acc_d = minor_step ? (err_sum - ErrBits'(major_delta)) : err_sum;
      if (x_major_q) begin
        pos_x_d = x_fwd;
        if (minor_step) begin
          pos_y_d = y_fwd;
        end
      end else begin
        pos_y_d = y_fwd;
        if (minor_step) begin
          pos_x_d = x_fwd;
        end
      end
      steps_left_d  = steps_left_q - CoordBits'(1);
      line_active_d = (steps_left_q != CoordBits'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q  <= FrameBaseRst;
      row_pitch_q   <= RowPitchRst;
      pixel_bytes_q <= PixelBytesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFrameBase:  frame_base_q  <= cfg_wdata_i[AddrBits-1:0];
        CfgRowPitch:   row_pitch_q   <= cfg_wdata_i[PitchBits-1:0];
        CfgPixelBytes: pixel_bytes_q <= cfg_wdata_i[PixBBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      err_acc_q     <= '0;
      steps_left_q  <= '0;
      delta_x_q     <= '0;
      delta_y_q     <= '0;
      step_x_neg_q  <= 1'b0;
      step_y_neg_q  <= 1'b0;
      x_major_q     <= 1'b0;
      line_color_q  <= '0;
      line_active_q <= 1'b0;
    end else begin
      pos_x_q       <= pos_x_d;
      pos_y_q       <= pos_y_d;
      err_acc_q     <= err_acc_d;
      steps_left_q  <= steps_left_d;
      delta_x_q     <= delta_x_d;
      delta_y_q     <= delta_y_d;
      step_x_neg_q  <= step_x_neg_d;
      step_y_neg_q  <= step_y_neg_d;
      x_major_q     <= x_major_d;
      line_color_q  <= line_color_d;
      line_active_q <= line_active_d;
    end
  end

  // pixel stage
  assign a_valid_d = a_ready ? gen_pixel : a_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_pixel) begin
      a_x_q     <= pos_x_d;
      a_y_q     <= pos_y_d;
      a_color_q <= line_color_q;
      a_last_q  <= !line_active_d;
    end
  end

  // address stage
  always_comb begin
    row_off  = RowOffBits'(a_y_q) * RowOffBits'(row_pitch_q);
    col_off  = ColOffBits'(a_x_q) * ColOffBits'(pixel_bytes_q);
    addr_sum = frame_base_q + AddrBits'(row_off) + AddrBits'(col_off);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_ready) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      out_pix_q.pixel_x       <= a_x_q;
      out_pix_q.pixel_y       <= a_y_q;
      out_pix_q.pixel_address <= addr_sum;
      out_pix_q.pixel_color   <= a_color_q;
      out_pix_q.last_pixel    <= a_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;

  `BLPG_NEVER(a_active_no_steps, clk_i, rst_ni, line_active_q && (steps_left_q == '0))
  `BLPG_ASSERT(a_err_bounded, clk_i, rst_ni,
               line_active_q |-> (err_acc_q <= ErrBits'(x_major_q ? delta_x_q : delta_y_q)))
  `BLPG_ASSERT(a_pixel_enters, clk_i, rst_ni, gen_pixel |=> a_valid_q)
  `BLPG_ASSERT(a_last_ends_line, clk_i, rst_ni,
               (gen_pixel && (steps_left_q == CoordBits'(1))) |=> (!line_active_q && a_last_q))
  `BLPG_ASSERT(a_stage_holds, clk_i, rst_ni,
               (a_valid_q && !b_ready) |=> (a_valid_q && $stable(a_x_q) && $stable(a_y_q)))

endmodule
